@@ hdl/fbpa_pkg.sv @@
// Shared types and constants for the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

   localparam int DEF_MAX_BLOCKS    = 1024;
   localparam int DEF_POINTER_BYTES = 8;

   localparam int INDEX_W  = 10;
   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 17;
   localparam int TOTAL_W  = 11;
   localparam int ALIGN_W  = 4;
   localparam int POOL_W   = 24;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 72;

   localparam logic [SIZE_W-1:0]  RST_REQ_SIZE = 17'd64;
   localparam logic [ALIGN_W-1:0] RST_ALIGN    = 4'd3;
   localparam logic [POOL_W-1:0]  RST_POOL     = 24'd65536;
   localparam logic [ADDR_W-1:0]  RST_BASE     = 32'd0;
   localparam logic [SIZE_W-1:0]  SIZE_LIMIT   = 17'd65536;

   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_FREE     = 2'd1,
      OP_FORMAT   = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_EXHAUSTED  = 2'd1,
      ST_NO_BLOCK   = 2'd2,
      ST_FREE_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_REQ_SIZE = 2'd0,
      CSR_ALIGN    = 2'd1,
      CSR_POOL     = 2'd2,
      CSR_BASE     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_ALLOC = 2'd1,
      S_DIV   = 2'd2,
      S_LINK  = 2'd3
   } fsm_type;

endpackage

`default_nettype wire

@@ hdl/fbpa_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module fbpa_divider
   import fbpa_pkg::*;
#(
   parameter int DIVIDEND_W = POOL_W,
   parameter int DIVISOR_W  = SIZE_W
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;

   always_comb begin
      logic [DIVISOR_W:0] shifted;
      logic [DIVISOR_W:0] diff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // dividend bits shift out of the top while quotient bits enter below
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ hdl/fixed_block_pool_allocator.sv @@
// Fixed-size block pool allocator: LIFO free list held in a link memory.
//
// Requests arrive on req_ (kind in tuser, block index in tdata) and each one
// gives exactly one response on rsp_. Allocate reads the link entry of the
// head block from the link memory (a registered read) while the block
// address product is formed. Free does one link memory write. Format runs a
// 24-step serial divider that computes the pool byte count / effective size,
// then one link memory entry is written per cycle, one per new block. The
// link memory needs no clearing after reset, since no entry can be read
// before a format or free has written it. Configuration registers are written
// through csr_ while no request is in flight; the user is bound to this, and
// the block itself does not enforce it.
`default_nettype none

module fixed_block_pool_allocator
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS    = DEF_MAX_BLOCKS,
   parameter int POINTER_BYTES = DEF_POINTER_BYTES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_W-1:0]       csr_wdata,
   // requests
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // [9:0] block_index
   input  wire logic [1:0]             req_tuser,   // [1:0] op
   // responses
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [9:0] granted_index, [41:10] granted_address, [58:42] effective_size,
   // [69:59] block_total
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [1:0]                  rsp_tuser    // [1:0] status
);

   localparam int AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW    = $clog2(MAX_BLOCKS + 1);
   localparam int PROD_W = AW + SIZE_W;

   // configuration registers
   logic [SIZE_W-1:0]  req_size_ff, req_size_in;
   logic [ALIGN_W-1:0] align_ff, align_in;
   logic [POOL_W-1:0]  pool_ff, pool_in;
   logic [ADDR_W-1:0]  base_ff, base_in;

   // allocator state
   fsm_type            state_ff, state_in;
   logic [AW-1:0]      head_ff, head_in;
   logic               empty_ff, empty_in;
   logic [SIZE_W-1:0]  size_force_ff, size_force_in;
   logic [CW-1:0]      blocks_ff, blocks_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [SIZE_W-1:0]  rsp_size_ff, rsp_size_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   // link memory: {last, next}
   logic [AW:0]        link_mem [MAX_BLOCKS];
   logic [AW:0]        rd_data_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [AW:0]        mem_wdata;

   // divider
   logic               div_start;
   logic               div_done;
   logic [POOL_W-1:0]  div_quot;

   logic               req_fire;
   op_type             req_op;
   logic [INDEX_W-1:0] req_index;
   logic [SIZE_W-1:0]  new_size;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);
   assign req_index  = req_tdata[INDEX_W-1:0];

   // effective block size for a format
   always_comb begin
      logic [SIZE_W:0] align_v;
      logic [SIZE_W:0] size_v;
      logic [SIZE_W:0] sum_v;
      align_v = (SIZE_W + 1)'(1) << align_ff;
      if (align_v < (SIZE_W + 1)'(POINTER_BYTES)) begin
         align_v = (SIZE_W + 1)'(POINTER_BYTES);
      end
      size_v = {1'b0, req_size_ff};
      if (size_v > {1'b0, SIZE_LIMIT}) begin
         size_v = {1'b0, SIZE_LIMIT};
      end
      if (size_v < (SIZE_W + 1)'(POINTER_BYTES)) begin
         size_v = (SIZE_W + 1)'(POINTER_BYTES);
      end
      sum_v    = (size_v + align_v - (SIZE_W + 1)'(1)) & ~(align_v - (SIZE_W + 1)'(1));
      new_size = sum_v[SIZE_W-1:0];
   end

   fbpa_divider #(
      .DIVIDEND_W (POOL_W),
      .DIVISOR_W  (SIZE_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pool_ff),
      .divisor  (new_size),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      logic [CW-1:0] count_v;
      logic [CW-1:0] cnt_next;
      req_size_in   = req_size_ff;
      align_in      = align_ff;
      pool_in       = pool_ff;
      base_in       = base_ff;
      state_in      = state_ff;
      head_in       = head_ff;
      empty_in      = empty_ff;
      size_force_in = size_force_ff;
      blocks_in     = blocks_ff;
      cnt_in        = cnt_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_total_in  = rsp_total_ff;
      mem_we        = 1'b0;
      mem_waddr     = head_ff;
      mem_wdata     = '0;
      div_start     = 1'b0;
      count_v       = (32'(div_quot) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(div_quot);
      cnt_next      = cnt_ff + CW'(1);

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_REQ_SIZE: req_size_in = csr_wdata[SIZE_W-1:0];
            CSR_ALIGN:    align_in    = csr_wdata[ALIGN_W-1:0];
            CSR_POOL:     pool_in     = csr_wdata[POOL_W-1:0];
            CSR_BASE:     base_in     = csr_wdata[ADDR_W-1:0];
            default:      ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_index_in = '0;
               rsp_addr_in  = '0;
               rsp_size_in  = size_force_ff;
               rsp_total_in = TOTAL_W'(blocks_ff);
               case (req_op)
                  OP_ALLOC: begin
                     if (empty_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = (blocks_ff == '0) ? ST_NO_BLOCK : ST_EXHAUSTED;
                     end else begin
                        // link entry of the head is read this cycle
                        prod_in  = PROD_W'(head_ff) * PROD_W'(size_force_ff);
                        state_in = S_ALLOC;
                     end
                  end
                  OP_FREE: begin
                     rsp_valid_in = 1'b1;
                     if (32'(req_index) >= 32'(blocks_ff)) begin
                        rsp_status_in = ST_FREE_RANGE;
                     end else begin
                        rsp_status_in = ST_OK;
                        mem_we    = 1'b1;
                        mem_waddr = AW'(req_index);
                        mem_wdata = {empty_ff, empty_ff ? AW'(0) : head_ff};
                        head_in   = AW'(req_index);
                        empty_in  = 1'b0;
                     end
                  end
                  OP_FORMAT: begin
                     div_start     = 1'b1;
                     size_force_in = new_size;
                     state_in      = S_DIV;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            head_in       = rd_data_ff[AW] ? AW'(0) : rd_data_ff[AW-1:0];
            empty_in      = rd_data_ff[AW];
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_index_in  = INDEX_W'(head_ff);
            rsp_addr_in   = base_ff + ADDR_W'(prod_ff);
            state_in      = S_IDLE;
         end
         S_DIV: begin
            if (div_done) begin
               blocks_in = count_v;
               cnt_in    = '0;
               if (count_v == '0) begin
                  head_in       = '0;
                  empty_in      = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NO_BLOCK;
                  rsp_index_in  = '0;
                  rsp_addr_in   = '0;
                  rsp_size_in   = size_force_ff;
                  rsp_total_in  = '0;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_LINK;
               end
            end
         end
         S_LINK: begin
            // chain block i to block i+1; last block carries the end mark
            mem_we    = 1'b1;
            mem_waddr = AW'(cnt_ff);
            mem_wdata = {(cnt_next == blocks_ff), AW'(cnt_next)};
            cnt_in    = cnt_next;
            if (cnt_next == blocks_ff) begin
               head_in       = '0;
               empty_in      = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_index_in  = '0;
               rsp_addr_in   = '0;
               rsp_size_in   = size_force_ff;
               rsp_total_in  = TOTAL_W'(blocks_ff);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_size_ff   <= RST_REQ_SIZE;
         align_ff      <= RST_ALIGN;
         pool_ff       <= RST_POOL;
         base_ff       <= RST_BASE;
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         empty_ff      <= 1'b1;
         size_force_ff <= '0;
         blocks_ff     <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         req_size_ff   <= req_size_in;
         align_ff      <= align_in;
         pool_ff       <= pool_in;
         base_ff       <= base_in;
         state_ff      <= state_in;
         head_ff       <= head_in;
         empty_ff      <= empty_in;
         size_force_ff <= size_force_in;
         blocks_ff     <= blocks_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_total_ff  <= rsp_total_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= link_mem[head_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_total_ff, rsp_size_ff, rsp_addr_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> head_ff == '0)
      else $error("empty free list with nonzero head");

   // the old head stays in place while a new pool is being linked
   a_head_in_pool: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LINK) && !empty_ff |-> 32'(head_ff) < 32'(blocks_ff))
      else $error("free list head outside the formatted pool");

   a_blocks_bound: assert property (@(posedge clock) disable iff (reset)
      32'(blocks_ff) <= 32'(MAX_BLOCKS))
      else $error("block count above capacity");

   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ALLOC |-> !mem_we && !rsp_valid_ff)
      else $error("link write or pending response during allocate read");

   a_link_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LINK |-> cnt_ff < blocks_ff)
      else $error("link sweep beyond block count");
`endif

endmodule

`default_nettype wire
